// ===== hdl/disc_interface_register_block_assert.svh =====
// ----------------------------------------------------------------------------
// disc interface register block assertion macros
// immediate-implication and next-cycle checks, reset disables both
// ----------------------------------------------------------------------------
`ifndef DISC_INTERFACE_REGISTER_BLOCK_ASSERT_SVH
`define DISC_INTERFACE_REGISTER_BLOCK_ASSERT_SVH

// same-cycle implication
`define DIRB_CHECK(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("disc interface check failed");

// next-cycle implication
`define DIRB_CHECK_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("disc interface check failed");

`endif

// ===== hdl/dirb_pkg.sv =====
// ----------------------------------------------------------------------------
// dirb_pkg
// types and constants shared by the disc interface register block
// ----------------------------------------------------------------------------
package dirb_pkg;

  // event codes
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_DONE  = 3'd2;
  localparam logic [2:0] CMD_COVER = 3'd3;
  localparam logic [2:0] CMD_BLOCK = 3'd4;

  // register indexes
  localparam logic [3:0] REG_STATUS  = 4'd0;
  localparam logic [3:0] REG_COVER   = 4'd1;
  localparam logic [3:0] REG_WORD0   = 4'd2;
  localparam logic [3:0] REG_WORD1   = 4'd3;
  localparam logic [3:0] REG_WORD2   = 4'd4;
  localparam logic [3:0] REG_ADDRESS = 4'd5;
  localparam logic [3:0] REG_LENGTH  = 4'd6;
  localparam logic [3:0] REG_CONTROL = 4'd7;
  localparam logic [3:0] REG_IMM     = 4'd8;

  // disc command opcodes
  localparam logic [7:0] OP_READ   = 8'hA8;
  localparam logic [7:0] OP_SEEK   = 8'hAB;
  localparam logic [7:0] OP_ERROR  = 8'hE0;
  localparam logic [7:0] OP_STREAM = 8'hE1;
  localparam logic [7:0] OP_QUERY  = 8'hE2;
  localparam logic [7:0] OP_CHANGE = 8'hE3;

  // sub codes
  localparam logic [1:0] STREAM_START = 2'd0;
  localparam logic [1:0] STREAM_STOP  = 2'd1;
  localparam logic [1:0] QRY_PLAYING  = 2'd0;
  localparam logic [1:0] QRY_POSITION = 2'd1;
  localparam logic [1:0] QRY_START    = 2'd2;

  localparam logic [31:0] COVER_ERROR_CODE = 32'h0102_3A00;
  localparam logic [31:0] LEN_MASK         = 32'h03FF_FFE0;
  localparam logic [31:0] BLOCK_BYTES      = 32'd512;
  localparam logic [31:0] ECC_ROUND        = 32'hFFFF_8000;
  localparam logic [6:0]  STATUS_CLR_MASK  = 7'b1010100;
  localparam logic [6:0]  STATUS_SET_MASK  = 7'b0101011;
  localparam logic [6:0]  STATUS_FLAG_MASK = 7'b0101010;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        read_request;
    logic [31:0] read_address;
    logic [31:0] read_length;
    logic [30:0] read_offset;
    logic        disc_change_request;
  } result_t;

endpackage

// ===== hdl/dirb_regs.sv =====
// ----------------------------------------------------------------------------
// dirb_regs
// register file, command execution and stream tracking, one event per transfer
// ----------------------------------------------------------------------------
`include "disc_interface_register_block_assert.svh"

module dirb_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                accept,
  input  logic [2:0]          command,
  input  logic [3:0]          reg_index,
  input  logic [31:0]         write_data,
  input  logic                disc_change_ok,
  output dirb_pkg::result_t   result
);

  logic        irq_enable;
  logic [6:0]  status_reg,      status_next;
  logic [2:0]  cover_reg,       cover_next;
  logic [31:0] word0,           word0_next;
  logic [31:0] word1,           word1_next;
  logic [31:0] word2,           word2_next;
  logic [31:0] dma_address,     dma_address_next;
  logic [31:0] dma_length,      dma_length_next;
  logic [2:0]  control_reg,     control_next;
  logic [31:0] immediate_reg,   immediate_next;
  logic        error_pending,   error_pending_next;
  logic        stream_playing,  stream_playing_next;
  logic        stream_stopping, stream_stopping_next;
  logic [31:0] stream_position, stream_position_next;
  logic [31:0] stream_start,    stream_start_next;
  logic [31:0] stream_length,   stream_length_next;
  logic [31:0] queued_start,    queued_start_next;
  logic [31:0] queued_length,   queued_length_next;

  logic [7:0]  op_code;
  logic [1:0]  sub_code;
  logic [30:0] offset;
  logic [31:0] round_offset;
  logic [31:0] round_length;
  logic [31:0] position_inc;
  logic [31:0] stream_end;
  logic        irq_pending;

  assign op_code      = word0[31:24];
  assign sub_code     = word0[17:16];
  assign offset       = {word1[28:0], 2'b00};
  assign round_offset = {1'b0, offset} & dirb_pkg::ECC_ROUND;
  assign round_length = word2 & dirb_pkg::ECC_ROUND;
  assign position_inc = stream_position + dirb_pkg::BLOCK_BYTES;
  assign stream_end   = stream_start + stream_length;

  always_comb begin
    logic        do_finish;
    logic        fin_dma;
    logic [31:0] imm_value;
    logic [6:0]  status_kept;
    logic [2:0]  cover_kept;

    status_next          = status_reg;
    cover_next           = cover_reg;
    word0_next           = word0;
    word1_next           = word1;
    word2_next           = word2;
    dma_address_next     = dma_address;
    dma_length_next      = dma_length;
    control_next         = control_reg;
    immediate_next       = immediate_reg;
    error_pending_next   = error_pending;
    stream_playing_next  = stream_playing;
    stream_stopping_next = stream_stopping;
    stream_position_next = stream_position;
    stream_start_next    = stream_start;
    stream_length_next   = stream_length;
    queued_start_next    = queued_start;
    queued_length_next   = queued_length;
    result               = '0;
    do_finish            = 1'b0;
    fin_dma              = control_reg[1];
    imm_value            = '0;
    status_kept          = status_reg & ~(write_data[6:0] & dirb_pkg::STATUS_CLR_MASK);
    cover_kept           = cover_reg & ~(write_data[2:0] & 3'b100);

    case (command)
      dirb_pkg::CMD_READ: begin
        case (reg_index)
          dirb_pkg::REG_STATUS:  result.read_data = {25'd0, status_reg};
          dirb_pkg::REG_COVER:   result.read_data = {29'd0, cover_reg};
          dirb_pkg::REG_WORD0:   result.read_data = word0;
          dirb_pkg::REG_WORD1:   result.read_data = word1;
          dirb_pkg::REG_WORD2:   result.read_data = word2;
          dirb_pkg::REG_ADDRESS: result.read_data = dma_address;
          dirb_pkg::REG_LENGTH:  result.read_data = dma_length;
          dirb_pkg::REG_CONTROL: result.read_data = {29'd0, control_reg};
          dirb_pkg::REG_IMM:     result.read_data = immediate_reg;
          default:               result.read_data = '0;
        endcase
      end
      dirb_pkg::CMD_WRITE: begin
        case (reg_index)
          dirb_pkg::REG_STATUS: begin
            status_next = (write_data[6:0] & dirb_pkg::STATUS_SET_MASK)
                        | (status_kept & ~dirb_pkg::STATUS_FLAG_MASK);
          end
          dirb_pkg::REG_COVER: begin
            cover_next = (write_data[2:0] & 3'b010) | (cover_kept & 3'b101);
          end
          dirb_pkg::REG_WORD0:   word0_next = write_data;
          dirb_pkg::REG_WORD1:   word1_next = write_data;
          dirb_pkg::REG_WORD2:   word2_next = write_data;
          dirb_pkg::REG_ADDRESS: dma_address_next = write_data & dirb_pkg::LEN_MASK;
          dirb_pkg::REG_LENGTH:  dma_length_next = write_data & dirb_pkg::LEN_MASK;
          dirb_pkg::REG_IMM:     immediate_next = write_data;
          dirb_pkg::REG_CONTROL: begin
            control_next = write_data[2:0];
            fin_dma      = write_data[1];
            if (write_data[0]) begin
              if (op_code == dirb_pkg::OP_READ || op_code == dirb_pkg::OP_SEEK) begin
                if (!cover_reg[0]) begin
                  result.read_request = 1'b1;
                  result.read_offset  = offset;
                  if (op_code == dirb_pkg::OP_READ) begin
                    result.read_address = dma_address;
                    result.read_length  = dma_length;
                  end
                end else begin
                  // cover open
                  error_pending_next = 1'b1;
                  status_next[2]     = 1'b1;
                  control_next[0]    = 1'b0;
                end
              end else begin
                do_finish = 1'b1;
                case (op_code)
                  dirb_pkg::OP_ERROR: begin
                    imm_value          = error_pending ? dirb_pkg::COVER_ERROR_CODE : '0;
                    error_pending_next = 1'b0;
                  end
                  dirb_pkg::OP_STREAM: begin
                    if (sub_code == dirb_pkg::STREAM_START) begin
                      if (round_offset == '0 && round_length == '0) begin
                        stream_stopping_next = 1'b1;
                      end else if (!stream_stopping) begin
                        queued_start_next  = round_offset;
                        queued_length_next = round_length;
                        if (!stream_playing) begin
                          stream_position_next = round_offset;
                          stream_start_next    = round_offset;
                          stream_length_next   = round_length;
                          stream_playing_next  = 1'b1;
                        end
                      end
                    end else if (sub_code == dirb_pkg::STREAM_STOP) begin
                      stream_stopping_next = 1'b0;
                      stream_playing_next  = 1'b0;
                    end
                  end
                  dirb_pkg::OP_QUERY: begin
                    case (sub_code)
                      dirb_pkg::QRY_PLAYING:  imm_value = {31'd0, stream_playing};
                      dirb_pkg::QRY_POSITION: imm_value = {3'd0, stream_position[30:15], 13'd0};
                      dirb_pkg::QRY_START:    imm_value = {3'd0, stream_start[30:15], 13'd0};
                      default:                imm_value = stream_length;
                    endcase
                  end
                  dirb_pkg::OP_CHANGE: begin
                    if (!cover_reg[0]) begin
                      result.disc_change_request = 1'b1;
                      if (disc_change_ok) begin
                        cover_next[0] = 1'b1;
                      end
                    end
                  end
                  default: imm_value = '0;
                endcase
                immediate_next = imm_value;
              end
            end
          end
          default: ;
        endcase
      end
      dirb_pkg::CMD_DONE: do_finish = 1'b1;
      dirb_pkg::CMD_COVER: cover_next = {1'b1, cover_reg[1], 1'b0};
      dirb_pkg::CMD_BLOCK: begin
        if (stream_playing) begin
          stream_position_next = position_inc;
          if (position_inc == stream_end) begin
            stream_position_next = queued_start;
            stream_start_next    = queued_start;
            stream_length_next   = queued_length;
            if (stream_stopping) begin
              stream_stopping_next = 1'b0;
              stream_playing_next  = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    if (do_finish) begin
      if (fin_dma) begin
        dma_address_next = dma_address + dma_length;
        dma_length_next  = '0;
      end
      status_next[4]  = 1'b1;
      control_next[0] = 1'b0;
    end

    irq_pending = (status_next[2] & status_next[1]) | (status_next[4] & status_next[3])
                | (status_next[6] & status_next[5]) | (cover_next[2] & cover_next[1]);
    result.irq_out = irq_pending & irq_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable <= 1'b0;
    end else if (cfg_write) begin
      irq_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg      <= '0;
      cover_reg       <= '0;
      word0           <= '0;
      word1           <= '0;
      word2           <= '0;
      dma_address     <= '0;
      dma_length      <= '0;
      control_reg     <= '0;
      immediate_reg   <= '0;
      error_pending   <= 1'b0;
      stream_playing  <= 1'b0;
      stream_stopping <= 1'b0;
      stream_position <= '0;
      stream_start    <= '0;
      stream_length   <= '0;
      queued_start    <= '0;
      queued_length   <= '0;
    end else if (accept) begin
      status_reg      <= status_next;
      cover_reg       <= cover_next;
      word0           <= word0_next;
      word1           <= word1_next;
      word2           <= word2_next;
      dma_address     <= dma_address_next;
      dma_length      <= dma_length_next;
      control_reg     <= control_next;
      immediate_reg   <= immediate_next;
      error_pending   <= error_pending_next;
      stream_playing  <= stream_playing_next;
      stream_stopping <= stream_stopping_next;
      stream_position <= stream_position_next;
      stream_start    <= stream_start_next;
      stream_length   <= stream_length_next;
      queued_start    <= queued_start_next;
      queued_length   <= queued_length_next;
    end
  end

  `DIRB_CHECK_NEXT(done_sets_flag, clk, rst,
    !rst && accept && command == dirb_pkg::CMD_DONE,
    status_reg[4] && !control_reg[0])
  `DIRB_CHECK(high_index_reads_zero, clk, rst,
    accept && command == dirb_pkg::CMD_READ && reg_index > dirb_pkg::REG_IMM,
    result.read_data == '0)
  `DIRB_CHECK_NEXT(idle_holds_state, clk, rst,
    !rst && !accept,
    $stable(status_reg) && $stable(cover_reg) && $stable(stream_position))

endmodule

// ===== hdl/dirb_out_buf.sv =====
// ----------------------------------------------------------------------------
// dirb_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`include "disc_interface_register_block_assert.svh"

module dirb_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  dirb_pkg::result_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output dirb_pkg::result_t dn_data
);

  logic              main_valid;
  logic              skid_valid;
  dirb_pkg::result_t main_data;
  dirb_pkg::result_t skid_data;
  logic              push;
  logic              pop;

  assign up_ready = !skid_valid;
  assign push     = up_valid && up_ready;
  assign pop      = main_valid && dn_ready;
  assign dn_valid = main_valid;
  assign dn_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : up_data;
    end else if (push && !main_valid) begin
      main_data <= up_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= up_data;
    end
  end

  `DIRB_CHECK(skid_behind_main, clk, rst, skid_valid, main_valid)
  `DIRB_CHECK_NEXT(stall_fills_skid, clk, rst,
    !rst && push && main_valid && !pop, skid_valid && main_valid)

endmodule

// ===== hdl/disc_interface_register_block.sv =====
// a result is registered in the output buffer before it is offered
// throughput: one input transfer per cycle while the skid register is empty, every event decoded in a single pass
// a two-entry output buffer lets the input take one more transfer while the output stalls
// reset (rst, synchronous) clears all registers, the interrupt enable and the buffer
// ----------------------------------------------------------------------------
// disc_interface_register_block
// disc interface register file with command execution and interrupt output
// ----------------------------------------------------------------------------
module disc_interface_register_block (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic        disc_change_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_out,
  output logic        read_request,
  output logic [31:0] read_address,
  output logic [31:0] read_length,
  output logic [30:0] read_offset,
  output logic        disc_change_request
);

  dirb_pkg::result_t step_result;
  dirb_pkg::result_t out_result;
  logic              accept;

  assign accept = in_valid && in_ready;

  dirb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .command        (command),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .disc_change_ok (disc_change_ok),
    .result         (step_result)
  );

  dirb_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (step_result),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_result)
  );

  assign read_data           = out_result.read_data;
  assign irq_out             = out_result.irq_out;
  assign read_request        = out_result.read_request;
  assign read_address        = out_result.read_address;
  assign read_length         = out_result.read_length;
  assign read_offset         = out_result.read_offset;
  assign disc_change_request = out_result.disc_change_request;

endmodule

// ===== tb/sv/disc_interface_register_block_tb.sv =====
// ----------------------------------------------------------------------------
// disc_interface_register_block_tb
// Drives register reads and writes, transfer done, cover close, stream block
// events and unused command codes through the valid/ready input. Each result
// is compared field by field against a cycle-free model of the register file
// kept in the bench. Both channels idle at random. The interrupt enable changes
// between traffic phases.
// ----------------------------------------------------------------------------
module disc_interface_register_block_tb;
  import dirb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] CMD_IDLE = 3'd7;
  localparam logic [3:0] REG_UNMAPPED = 4'd15;
  localparam logic [7:0] OP_UNKNOWN = 8'h55;
  localparam logic [31:0] CTRL_RUN = 32'd1;
  localparam logic [31:0] CTRL_RUN_ADVANCE = 32'd3;
  localparam int N_DIRECTED = 26;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  idx;
    logic [31:0] data;
    logic        chg;
    logic        typed;
    logic [31:0] want;
  } directed_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = '0;
  logic [3:0]  reg_index = '0;
  logic [31:0] write_data = '0;
  logic        disc_change_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        irq_out;
  logic        read_request;
  logic [31:0] read_address;
  logic [31:0] read_length;
  logic [30:0] read_offset;
  logic        disc_change_request;

  // register file model
  logic        irq_en_m = 1'b0;
  logic [6:0]  status_m = '0;
  logic [2:0]  cover_m = '0;
  logic [31:0] cmd_word [0:2] = '{32'h0, 32'h0, 32'h0};
  logic [31:0] dma_addr_m = '0;
  logic [31:0] dma_len_m = '0;
  logic [2:0]  ctrl_m = '0;
  logic [31:0] imm_m = '0;
  logic        err_pend = 1'b0;
  logic        playing = 1'b0;
  logic        stopping = 1'b0;
  logic [31:0] pos = '0;
  logic [31:0] st_start = '0;
  logic [31:0] st_len = '0;
  logic [31:0] q_start = '0;
  logic [31:0] q_len = '0;

  result_t pending_results [$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      live_items = 0;
  int      burst_left = 0;
  int      cycle_count = 0;
  bit      offering = 1'b0;

  logic [7:0] opcode_pool [0:5] = '{OP_READ, OP_SEEK, OP_ERROR, OP_STREAM, OP_QUERY,
                                    OP_CHANGE};

  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{CMD_READ,  REG_STATUS,   32'h0,               1'b0, 1'b1, 32'h0},
    '{CMD_READ,  REG_UNMAPPED, 32'h0,               1'b0, 1'b1, 32'h0},
    '{CMD_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF,       1'b1, 1'b0, 32'h0},
    '{CMD_READ,  REG_UNMAPPED, 32'hFFFF_FFFF,       1'b0, 1'b1, 32'h0},
    '{CMD_WRITE, REG_STATUS,   32'hFFFF_FFFF,       1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_COVER,    32'hFFFF_FFFF,       1'b0, 1'b0, 32'h0},
    '{CMD_COVER, REG_STATUS,   32'h0,               1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_ADDRESS,  32'hFFFF_FFFF,       1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_LENGTH,   32'h0000_0100,       1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_WORD1,    32'hFFFF_FFFF,       1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_WORD0,    {OP_READ, 24'h0},    1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_CONTROL,  CTRL_RUN_ADVANCE,    1'b0, 1'b0, 32'h0},
    '{CMD_DONE,  REG_STATUS,   32'h0,               1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_WORD0,    {OP_CHANGE, 24'h0},  1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_CONTROL,  CTRL_RUN,            1'b1, 1'b0, 32'h0},
    '{CMD_WRITE, REG_WORD0,    {OP_SEEK, 24'h0},    1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_CONTROL,  CTRL_RUN,            1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_WORD0,    {OP_ERROR, 24'h0},   1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_CONTROL,  CTRL_RUN,            1'b0, 1'b0, 32'h0},
    '{CMD_READ,  REG_IMM,      32'h0,               1'b0, 1'b1, COVER_ERROR_CODE},
    '{CMD_WRITE, REG_WORD0,    {OP_UNKNOWN, 24'h0}, 1'b0, 1'b0, 32'h0},
    '{CMD_WRITE, REG_CONTROL,  CTRL_RUN,            1'b0, 1'b0, 32'h0},
    '{CMD_READ,  REG_IMM,      32'h0,               1'b0, 1'b1, 32'h0},
    '{CMD_IDLE,  REG_UNMAPPED, 32'hFFFF_FFFF,       1'b1, 1'b0, 32'h0},
    '{CMD_WRITE, REG_IMM,      32'hFFFF_FFFF,       1'b0, 1'b0, 32'h0},
    '{CMD_BLOCK, REG_STATUS,   32'h0,               1'b0, 1'b0, 32'h0}
  };

  disc_interface_register_block dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .reg_index(reg_index),
    .write_data(write_data),
    .disc_change_ok(disc_change_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .irq_out(irq_out),
    .read_request(read_request),
    .read_address(read_address),
    .read_length(read_length),
    .read_offset(read_offset),
    .disc_change_request(disc_change_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void complete_transfer();
    if (ctrl_m[1]) begin
      dma_addr_m = dma_addr_m + dma_len_m;
      dma_len_m = '0;
    end
    status_m[4] = 1'b1;
    ctrl_m[0] = 1'b0;
  endfunction

  function automatic result_t register_file_step(input logic [2:0] cmd, input logic [3:0] idx,
                                                 input logic [31:0] wdata,
                                                 input logic change_ok);
    result_t r;
    logic [7:0] opcode;
    logic [1:0] sub;
    logic [30:0] offs;
    logic [31:0] so;
    logic [31:0] sl;
    logic [31:0] answer;
    r = '0;
    case (cmd)
      CMD_READ: begin
        case (idx)
          REG_STATUS: r.read_data = {25'd0, status_m};
          REG_COVER: r.read_data = {29'd0, cover_m};
          REG_WORD0, REG_WORD1, REG_WORD2: r.read_data = cmd_word[2'(idx - REG_WORD0)];
          REG_ADDRESS: r.read_data = dma_addr_m;
          REG_LENGTH: r.read_data = dma_len_m;
          REG_CONTROL: r.read_data = {29'd0, ctrl_m};
          REG_IMM: r.read_data = imm_m;
          default: r.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (idx)
          REG_STATUS: begin
            status_m = (wdata[6:0] & STATUS_SET_MASK) |
                       (status_m & ~(wdata[6:0] & STATUS_CLR_MASK) & ~STATUS_FLAG_MASK);
          end
          REG_COVER: cover_m = {cover_m[2] & ~wdata[2], wdata[1], cover_m[0]};
          REG_WORD0, REG_WORD1, REG_WORD2: cmd_word[2'(idx - REG_WORD0)] = wdata;
          REG_ADDRESS: dma_addr_m = wdata & LEN_MASK;
          REG_LENGTH: dma_len_m = wdata & LEN_MASK;
          REG_CONTROL: begin
            ctrl_m = wdata[2:0];
            if (wdata[0]) begin
              opcode = cmd_word[0][31:24];
              sub = cmd_word[0][17:16];
              offs = {cmd_word[1][28:0], 2'b00};
              if (opcode == OP_READ || opcode == OP_SEEK) begin
                if (!cover_m[0]) begin
                  r.read_request = 1'b1;
                  if (opcode == OP_READ) begin
                    r.read_address = dma_addr_m;
                    r.read_length = dma_len_m;
                  end
                  r.read_offset = offs;
                end else begin
                  // cover open: post the error instead of reading
                  err_pend = 1'b1;
                  status_m[2] = 1'b1;
                  ctrl_m[0] = 1'b0;
                end
              end else begin
                answer = '0;
                case (opcode)
                  OP_ERROR: begin
                    answer = err_pend ? COVER_ERROR_CODE : '0;
                    err_pend = 1'b0;
                  end
                  OP_STREAM: begin
                    so = {1'b0, offs} & ECC_ROUND;
                    sl = cmd_word[2] & ECC_ROUND;
                    if (sub == STREAM_START) begin
                      if (so == '0 && sl == '0) begin
                        stopping = 1'b1;
                      end else if (!stopping) begin
                        q_start = so;
                        q_len = sl;
                        if (!playing) begin
                          pos = so;
                          st_start = so;
                          st_len = sl;
                          playing = 1'b1;
                        end
                      end
                    end else if (sub == STREAM_STOP) begin
                      stopping = 1'b0;
                      playing = 1'b0;
                    end
                  end
                  OP_QUERY: begin
                    case (sub)
                      QRY_PLAYING: answer = {31'd0, playing};
                      QRY_POSITION: answer = ({1'b0, pos[30:0]} & ECC_ROUND) >> 2;
                      QRY_START: answer = ({1'b0, st_start[30:0]} & ECC_ROUND) >> 2;
                      default: answer = st_len;
                    endcase
                  end
                  OP_CHANGE: begin
                    if (!cover_m[0]) begin
                      r.disc_change_request = 1'b1;
                      if (change_ok) cover_m[0] = 1'b1;
                    end
                  end
                  default: ;
                endcase
                imm_m = answer;
                complete_transfer();
              end
            end
          end
          REG_IMM: imm_m = wdata;
          default: ;
        endcase
      end
      CMD_DONE: complete_transfer();
      CMD_COVER: begin
        cover_m[0] = 1'b0;
        cover_m[2] = 1'b1;
      end
      CMD_BLOCK: begin
        if (playing) begin
          pos = pos + BLOCK_BYTES;
          if (pos == st_start + st_len) begin
            pos = q_start;
            st_start = q_start;
            st_len = q_len;
            if (stopping) begin
              stopping = 1'b0;
              playing = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.irq_out = irq_en_m & ((|((status_m >> 1) & status_m & STATUS_FLAG_MASK)) |
                            (cover_m[2] & cover_m[1]));
    return r;
  endfunction

  task automatic offer_event(input logic [2:0] c, input logic [3:0] ix, input logic [31:0] d,
                             input logic k, input logic use_typed,
                             input logic [31:0] typed_read);
    result_t r;
    int gap;
    if (c <= CMD_BLOCK && !(c == CMD_BLOCK && !playing) && !(c == CMD_WRITE && ix > REG_IMM))
      live_items++;
    in_valid <= 1'b1;
    offering = 1'b1;
    command <= c;
    reg_index <= ix;
    write_data <= d;
    disc_change_ok <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = register_file_step(c, ix, d, k);
    if (use_typed) begin
      r = '0;
      r.read_data = typed_read;
    end
    pending_results.push_back(r);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic write_irq_enable(input logic v);
    stop_offering();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    irq_en_m = v;
  endtask

  task automatic run_random_traffic(input int count);
    int stop_at;
    int pick;
    logic [7:0] op;
    logic [31:0] w;
    logic [31:0] w1;
    logic [31:0] w2;
    stop_at = live_items + count;
    while (live_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // command sequence: word 0, optional operands, the run bit, then an optional immediate read
        op = ($urandom_range(0, 7) == 0) ? 8'($urandom) : opcode_pool[$urandom_range(0, 5)];
        if ($urandom_range(0, 2) == 0) op = OP_STREAM;
        w = $urandom;
        w[31:24] = op;
        if ($urandom_range(0, 1) == 0) w[17:16] = STREAM_START;
        offer_event(CMD_WRITE, REG_WORD0, w, 1'($urandom), 1'b0, '0);
        if (op == OP_STREAM || $urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            // zero start and length asks the stream to stop at its end
            w1 = $urandom_range(0, 8191);
            w2 = $urandom_range(0, 32767);
          end else begin
            w1 = $urandom;
            w2 = ($urandom_range(0, 3) == 0) ? $urandom_range(32'h10000, 32'h17FFF)
                                             : $urandom_range(32'h8000, 32'hFFFF);
          end
          offer_event(CMD_WRITE, REG_WORD1, w1, 1'($urandom), 1'b0, '0);
          offer_event(CMD_WRITE, REG_WORD2, w2, 1'($urandom), 1'b0, '0);
        end
        if ($urandom_range(0, 3) == 0) begin
          offer_event(CMD_WRITE, REG_ADDRESS, $urandom, 1'($urandom), 1'b0, '0);
          offer_event(CMD_WRITE, REG_LENGTH, $urandom, 1'($urandom), 1'b0, '0);
        end
        w = $urandom;
        w[0] = 1'b1;
        offer_event(CMD_WRITE, REG_CONTROL, w, 1'($urandom), 1'b0, '0);
        if ($urandom_range(0, 1) == 0)
          offer_event(CMD_READ, REG_IMM, $urandom, 1'($urandom), 1'b0, '0);
      end else if (pick < 55) begin
        repeat (playing ? $urandom_range(1, 40) : $urandom_range(1, 2))
          offer_event(CMD_BLOCK, 4'($urandom), $urandom, 1'($urandom), 1'b0, '0);
      end else if (pick < 65) begin
        offer_event(CMD_DONE, 4'($urandom), $urandom, 1'($urandom), 1'b0, '0);
      end else if (pick < 73) begin
        offer_event(CMD_COVER, 4'($urandom), $urandom, 1'($urandom), 1'b0, '0);
      end else if (pick < 85) begin
        offer_event(CMD_WRITE, 4'($urandom), $urandom, 1'($urandom), 1'b0, '0);
      end else if (pick < 95) begin
        offer_event(CMD_READ, 4'($urandom), $urandom, 1'($urandom), 1'b0, '0);
      end else begin
        offer_event(3'($urandom_range(CMD_BLOCK + 1, CMD_IDLE)), 4'($urandom), $urandom,
                    1'($urandom), 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: compare each transfer, stall on a rotating pattern
  initial begin : result_monitor
    result_t want;
    int rx_cycle;
    int hold_left;
    bit held_once;
    rx_cycle = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: actual read_data %h", $time, read_data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("irq_out", 32'(want.irq_out), 32'(irq_out));
          check_field("read_request", 32'(want.read_request), 32'(read_request));
          check_field("read_address", want.read_address, read_address);
          check_field("read_length", want.read_length, read_length);
          check_field("read_offset", 32'(want.read_offset), 32'(read_offset));
          check_field("disc_change_request", 32'(want.disc_change_request),
                      32'(disc_change_request));
        end
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && results_seen >= 200) begin
        // long hold so the block fills and backs up its input
        held_once = 1'b1;
        hold_left = 150;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 50) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 3 == 0);
          default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      offer_event(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].data,
                  directed_rows[i].chg, directed_rows[i].typed, directed_rows[i].want);
    write_irq_enable(1'b1);
    run_random_traffic(150);
    write_irq_enable(1'b0);
    run_random_traffic(150);
    write_irq_enable(1'b1);
    run_random_traffic(150);
    stop_offering();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== disc_interface_register_block.f =====
+incdir+hdl
hdl/dirb_pkg.sv
hdl/dirb_regs.sv
hdl/dirb_out_buf.sv
hdl/disc_interface_register_block.sv
tb/sv/disc_interface_register_block_tb.sv
